@@ rtl/sfp_pkg.sv @@
// Shared types and constants of the sensor frame parser.
package sfp_pkg;

  // Frame geometry.
  localparam int FRAME_BYTES   = 32;
  localparam int ROWS          = FRAME_BYTES / 2;
  localparam int ROW_W         = $clog2(ROWS);
  localparam int CNT_W         = $clog2(FRAME_BYTES);
  localparam int DATA_WORDS    = 12;

  // Byte positions of interest within a frame.
  localparam logic [CNT_W-1:0] POS_PAT_FIRST = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_PAT_LAST  = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_SVC_HI    = CNT_W'(6);
  localparam logic [CNT_W-1:0] POS_SVC_LO    = CNT_W'(7);
  localparam logic [CNT_W-1:0] POS_SVC_NEXT  = CNT_W'(8);
  localparam logic [CNT_W-1:0] POS_DAT_HI    = CNT_W'(30);
  localparam logic [CNT_W-1:0] POS_DAT_LO    = CNT_W'(31);

  // First buffer row that holds a measurement word (bytes 4 and 5).
  localparam logic [ROW_W-1:0] ROW_DATA0     = ROW_W'(2);
  localparam logic [3:0]       LAST_WORD     = 4'(DATA_WORDS - 1);

  // Confirmation patterns on bytes 2 to 5.
  localparam logic [31:0] PAT_ACTIVE  = 32'h0004_E101;
  localparam logic [31:0] PAT_PASSIVE = 32'h0004_E100;
  localparam logic [31:0] PAT_SLEEP   = 32'h0004_E400;

  // Result kinds.
  localparam logic [2:0] KIND_PASSIVE = 3'd0;
  localparam logic [2:0] KIND_SLEEP   = 3'd1;
  localparam logic [2:0] KIND_ACTIVE  = 3'd2;
  localparam logic [2:0] KIND_DATA    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // a request is accepted this cycle
    logic rd;     // read the buffer row of the current word
    logic next;   // advance to the next word
  } sfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic single;     // the offered byte causes one confirm or error result
    logic data_ok;    // the offered byte completes a valid data frame
    logic last_word;  // the current word is the final one
  } sfp_status_t;

endpackage

@@ rtl/sensor_frame_parser_unit.sv @@
// Sensor frame parser: one received byte per request, confirm, data-word and error results.
// A byte with no result leaves the parser idle; the next request is taken the cycle after.
// A confirm or error result shows in the cycle after the byte and holds until taken.
// A good data frame gives twelve words, each a buffer row read, then a result held through
// output stalls; the frame buffer has a single read port, so words are read one at a time.
// Synchronous active-low reset clears the byte count, the running sum and the controller.
module sensor_frame_parser_unit import sfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [3:0]  out_word_index,
  output logic [15:0] out_word_value,
  output logic        out_last_of_run
);

  sfp_cmd_t    cmd;
  sfp_status_t status;

  // Sequencing of requests and results.
  sfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Frame buffer, checks and result payload.
  sfp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_rx_byte      (in_rx_byte),
    .cmd             (cmd),
    .status          (status),
    .out_event_kind  (out_event_kind),
    .out_word_index  (out_word_index),
    .out_word_value  (out_word_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule

@@ rtl/sfp_dp.sv @@
// Datapath of the sensor frame parser: frame buffer, counters, checks, result registers.
module sfp_dp import sfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_rx_byte,
  input  sfp_cmd_t          cmd,
  output sfp_status_t       status,
  output logic [2:0]        out_event_kind,
  output logic [3:0]        out_word_index,
  output logic [15:0]       out_word_value,
  output logic              out_last_of_run
);

  // Frame buffer: one row per byte pair, high byte first.
  logic [15:0]      mem_r [ROWS];

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [15:0]      chk_sum_r;
  logic [7:0]       hi_r;
  logic [31:0]      pat_r;
  logic [2:0]       kind_r, kind_nxt;
  logic [3:0]       word_idx_r;
  logic [15:0]      rd_data_r;
  logic             svc_sum_ok;
  logic             is_active, is_passive, is_sleep;
  logic             confirm, dat_sum_ok;
  logic [ROW_W-1:0] rd_row;

  // Checks on the offered byte against the captured sums and pattern.
  assign svc_sum_ok = (chk_sum_r == {hi_r, in_rx_byte});
  assign dat_sum_ok = svc_sum_ok;
  assign is_active  = (pat_r == PAT_ACTIVE);
  assign is_passive = (pat_r == PAT_PASSIVE);
  assign is_sleep   = (pat_r == PAT_SLEEP);
  assign confirm    = (cnt_r == POS_SVC_LO) && svc_sum_ok &&
                      (is_active || is_passive || is_sleep);

  assign status.single    = confirm || ((cnt_r == POS_DAT_LO) && !dat_sum_ok);
  assign status.data_ok   = (cnt_r == POS_DAT_LO) && dat_sum_ok;
  assign status.last_word = (word_idx_r == LAST_WORD);

  // Next count, sum and result kind for an accepted byte.
  always_comb begin
    cnt_nxt  = cnt_r + CNT_W'(1);
    sum_nxt  = sum_r + 16'(in_rx_byte);
    kind_nxt = kind_r;
    if (confirm) begin
      cnt_nxt = '0;
      sum_nxt = '0;
      if (is_active) begin
        kind_nxt = KIND_ACTIVE;
      end else if (is_passive) begin
        kind_nxt = KIND_PASSIVE;
      end else begin
        kind_nxt = KIND_SLEEP;
      end
    end else if (cnt_r == POS_SVC_LO) begin
      cnt_nxt = POS_SVC_NEXT;
    end else if (cnt_r == POS_DAT_LO) begin
      cnt_nxt  = '0;
      sum_nxt  = '0;
      kind_nxt = dat_sum_ok ? KIND_DATA : KIND_ERROR;
    end
  end

  // Control registers: byte count and running sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else if (cmd.take) begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Captured checksum operands, pattern bytes and result kind.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r <= kind_nxt;
      if ((cnt_r == POS_SVC_HI) || (cnt_r == POS_DAT_HI)) begin
        chk_sum_r <= sum_r;
        hi_r      <= in_rx_byte;
      end
      if ((cnt_r >= POS_PAT_FIRST) && (cnt_r <= POS_PAT_LAST)) begin
        pat_r <= {pat_r[23:0], in_rx_byte};
      end
    end
  end

  // Buffer write, one byte lane per accepted byte.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (cnt_r[0]) begin
        mem_r[cnt_r[CNT_W-1:1]][7:0] <= in_rx_byte;
      end else begin
        mem_r[cnt_r[CNT_W-1:1]][15:8] <= in_rx_byte;
      end
    end
  end

  // Word sequencing and registered buffer read.
  assign rd_row = ROW_DATA0 + ROW_W'(word_idx_r);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      word_idx_r <= '0;
    end else if (cmd.next) begin
      word_idx_r <= word_idx_r + 4'd1;
    end
    if (cmd.rd) begin
      rd_data_r <= mem_r[rd_row];
    end
  end

  // Result payload.
  assign out_event_kind  = kind_r;
  assign out_word_index  = (kind_r == KIND_DATA) ? word_idx_r : 4'd0;
  assign out_word_value  = (kind_r == KIND_DATA) ? rd_data_r : 16'd0;
  assign out_last_of_run = (kind_r != KIND_DATA) || (word_idx_r == LAST_WORD);

endmodule

@@ rtl/sfp_ctrl.sv @@
// Controller state machine of the sensor frame parser.
module sfp_ctrl import sfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  sfp_status_t status,
  output sfp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SINGLE = 4'b0010,
    ST_READ   = 4'b0100,
    ST_WORD   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Handshake outputs follow the state alone.
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_SINGLE) || (state_r == ST_WORD);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (status.single) begin
            state_nxt = ST_SINGLE;
          end else if (status.data_ok) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_SINGLE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WORD;
      end
      ST_WORD: begin
        if (!out_stall) begin
          if (status.last_word) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ tb/sensor_frame_parser_unit_tb.sv @@
// Self-checking testbench for the sensor frame parser: framed byte traffic against a frame tracker.
module sensor_frame_parser_unit_tb import sfp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SERVICE_LEN = 8;
  localparam int SUM_BYTES   = FRAME_BYTES - 2;
  localparam int RANDOM_ITEMS = 330;

  // One result of the parser as it appears on the output port.
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  index;
    logic [15:0] value;
    logic        last;
  } parser_event_t;

  // Tracks the frame position and running sum and keeps the events still owed.
  class parser_tracker;
    logic [7:0]    frame_bytes [FRAME_BYTES];
    logic [4:0]    fill;
    logic [15:0]   byte_sum;
    parser_event_t pending_events [$];
    int errors;
    int n_bytes;
    int n_events;
    int n_confirms;
    int n_data_frames;
    int n_bad_frames;

    function new();
      fill = '0;
      byte_sum = '0;
      errors = 0;
      n_bytes = 0;
      n_events = 0;
      n_confirms = 0;
      n_data_frames = 0;
      n_bad_frames = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
    endfunction

    function void owe(logic [2:0] kind, logic [3:0] index, logic [15:0] value, logic last);
      parser_event_t ev;
      ev.kind = kind;
      ev.index = index;
      ev.value = value;
      ev.last = last;
      pending_events.push_back(ev);
    endfunction

    // Store one accepted byte and work out the events it causes.
    function void take_byte(logic [7:0] rx);
      logic [5:0]  filled;
      logic [15:0] chk;
      logic [31:0] pat;
      frame_bytes[fill] = rx;
      byte_sum = byte_sum + 16'(rx);
      filled = 6'(fill) + 6'd1;
      fill = filled[4:0];
      n_bytes++;

      // Service frame test after the eighth byte.
      if (filled == 6'(SERVICE_LEN)) begin
        chk = byte_sum - 16'(frame_bytes[6]) - 16'(frame_bytes[7]);
        if (chk == {frame_bytes[6], frame_bytes[7]}) begin
          pat = {frame_bytes[2], frame_bytes[3], frame_bytes[4], frame_bytes[5]};
          if (pat == PAT_ACTIVE || pat == PAT_PASSIVE || pat == PAT_SLEEP) begin
            if (pat == PAT_ACTIVE) owe(KIND_ACTIVE, 4'd0, 16'd0, 1'b1);
            else if (pat == PAT_PASSIVE) owe(KIND_PASSIVE, 4'd0, 16'd0, 1'b1);
            else owe(KIND_SLEEP, 4'd0, 16'd0, 1'b1);
            n_confirms++;
            fill = '0;
            byte_sum = '0;
          end
        end
      end else if (filled == 6'(FRAME_BYTES)) begin
        // Full frame: checksum over bytes 0 to 29 against the last two.
        chk = byte_sum - 16'(frame_bytes[30]) - 16'(frame_bytes[31]);
        fill = '0;
        byte_sum = '0;
        if (chk == {frame_bytes[30], frame_bytes[31]}) begin
          for (int w = 0; w < DATA_WORDS; w++)
            owe(KIND_DATA, 4'(w), {frame_bytes[4 + 2 * w], frame_bytes[5 + 2 * w]},
                w == DATA_WORDS - 1);
          n_data_frames++;
        end else begin
          owe(KIND_ERROR, 4'd0, 16'd0, 1'b1);
          n_bad_frames++;
        end
      end
    endfunction

    // Compare one accepted result with the oldest owed event.
    function void match_event(parser_event_t got);
      parser_event_t want;
      n_events++;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result kind=%0d index=%0d value=%h last=%0d",
                 $time, got.kind, got.index, got.value, got.last);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: event_kind expected %0d, got %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.index !== want.index) begin
        $display("%0t: word_index expected %0d, got %0d", $time, want.index, got.index);
        errors++;
      end
      if (got.value !== want.value) begin
        $display("%0t: word_value expected %h, got %h", $time, want.value, got.value);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_of_run expected %0d, got %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_kind;
  logic [3:0]  out_word_index;
  logic [15:0] out_word_value;
  logic        out_last_of_run;

  parser_tracker tracker = new();
  logic [7:0]    frame_buf [FRAME_BYTES];
  int            random_start;

  sensor_frame_parser_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_word_index  (out_word_index),
    .out_word_value  (out_word_value),
    .out_last_of_run (out_last_of_run)
  );

  always #6 clk = ~clk;

  // Offer one byte after a random gap and hold it until the request is taken.
  task automatic send_byte(input logic [7:0] rx);
    int gap;
    gap = (tracker.n_bytes % 64 < 16) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= rx;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(rx);
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_byte(frame_buf[i]);
  endtask

  function automatic logic [31:0] any_pattern();
    case ($urandom_range(0, 2))
      0: return PAT_ACTIVE;
      1: return PAT_PASSIVE;
      default: return PAT_SLEEP;
    endcase
  endfunction

  // Eight-byte service frame; a flaw breaks the sum or flips one pattern bit.
  task automatic send_service(input logic [31:0] pat, input int flaw);
    logic [15:0] sum;
    if (flaw == 2) pat = pat ^ (32'd1 << $urandom_range(0, 31));
    frame_buf[0] = 8'($urandom);
    frame_buf[1] = 8'($urandom);
    {frame_buf[2], frame_buf[3], frame_buf[4], frame_buf[5]} = pat;
    sum = '0;
    for (int i = 0; i < 6; i++) sum = sum + 16'(frame_buf[i]);
    if (flaw == 1) sum = sum + 16'($urandom_range(1, 65535));
    {frame_buf[6], frame_buf[7]} = sum;
    send_frame(SERVICE_LEN);
  endtask

  // Full data frame. The header option plants a near-miss service frame in bytes 0 to 7.
  task automatic send_data(input int content, input int header, input bit good);
    logic [15:0] sum;
    for (int i = 0; i < SUM_BYTES; i++) begin
      case (content)
        0: frame_buf[i] = 8'h00;
        1: frame_buf[i] = 8'hFF;
        2: frame_buf[i] = 8'($urandom_range(0, 3));
        default: frame_buf[i] = 8'($urandom);
      endcase
    end
    if (header == 1)
      {frame_buf[2], frame_buf[3], frame_buf[4], frame_buf[5]} = any_pattern();
    if (header == 2) begin
      sum = '0;
      for (int i = 0; i < 6; i++) sum = sum + 16'(frame_buf[i]);
      {frame_buf[6], frame_buf[7]} = sum;
    end
    sum = '0;
    for (int i = 0; i < SUM_BYTES; i++) sum = sum + 16'(frame_buf[i]);
    if (!good) sum = sum ^ 16'($urandom_range(1, 65535));
    {frame_buf[30], frame_buf[31]} = sum;
    send_frame(FRAME_BYTES);
  endtask

  // Result side: random stall before each result, with stretches of none.
  initial begin
    int hold;
    parser_event_t got;
    wait (rst_n === 1'b1);
    forever begin
      hold = (tracker.n_events % 48 < 12) ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.kind = out_event_kind;
      got.index = out_word_index;
      got.value = out_word_value;
      got.last = out_last_of_run;
      tracker.match_event(got);
    end
  end

  // Main sequence: reset, directed frames, random traffic, drain.
  initial begin
    int pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Each confirmation kind once.
    send_service(PAT_ACTIVE, 0);
    send_service(PAT_PASSIVE, 0);
    send_service(PAT_SLEEP, 0);
    random_start = tracker.n_bytes;

    // Extreme content first: all zeros and all ones, both valid.
    send_data(0, 0, 1'b1);
    send_data(1, 0, 1'b1);

    while (tracker.n_bytes - random_start < RANDOM_ITEMS) begin
      // Out of step after noise or a broken service frame: fill with random bytes.
      while (tracker.fill != 0) send_byte(8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 30) send_service(any_pattern(), 0);
      else if (pick < 40) send_service(any_pattern(), $urandom_range(1, 2));
      else if (pick < 70) send_data($urandom_range(0, 9), 0, 1'b1);
      else if (pick < 80) send_data($urandom_range(0, 9), 0, 1'b0);
      else if (pick < 90) send_data($urandom_range(2, 9), $urandom_range(1, 2), 1'b1);
      else begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Let the owed events drain, then watch for stray results.
    while (tracker.pending_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Drove %0d bytes in %0d cycles of random idling on both sides.",
             tracker.n_bytes, $time / 12);
    $display("Checked %0d results: %0d confirms, %0d data frames, %0d frame errors.",
             tracker.n_events, tracker.n_confirms, tracker.n_data_frames,
             tracker.n_bad_frames);
    if (tracker.errors == 0 && tracker.pending_events.size() == 0) begin
      $display("sensor_frame_parser_unit regression: pass");
    end else begin
      $display("sensor_frame_parser_unit regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still owed.", tracker.pending_events.size());
    $display("sensor_frame_parser_unit regression: fail");
    $finish;
  end

endmodule
